>>> src/pba_pkg.sv
// pba_pkg: shared constants, control struct and arctangent table for the
// point bearing angle pipeline. No dependencies.
package pba_pkg;

  localparam int ScaleBits = 24;
  localparam int ZW        = 37;
  localparam int AtanFrac  = 32;
  localparam int MaxSteps  = 24;
  localparam int BearingW  = 16;

  localparam logic [ZW-1:0] PiQ32    = 37'd13493037705;
  localparam logic [ZW-1:0] TwoPiQ32 = 37'd26986075409;

  typedef struct packed {
    logic valid;
    logic zero;
  } ctl_t;

  // atan(2^-idx) in radians, 32 fraction bits
  function automatic logic [ZW-1:0] atan_q32(input int unsigned idx);
    logic [ZW-1:0] a;
    case (idx)
      0:  a = 37'd3373259426;
      1:  a = 37'd1991351318;
      2:  a = 37'd1052175346;
      3:  a = 37'd534100635;
      4:  a = 37'd268086748;
      5:  a = 37'd134174063;
      6:  a = 37'd67103403;
      7:  a = 37'd33553749;
      8:  a = 37'd16777131;
      9:  a = 37'd8388597;
      10: a = 37'd4194303;
      11: a = 37'd2097152;
      12: a = 37'd1048576;
      13: a = 37'd524288;
      14: a = 37'd262144;
      15: a = 37'd131072;
      16: a = 37'd65536;
      17: a = 37'd32768;
      18: a = 37'd16384;
      19: a = 37'd8192;
      20: a = 37'd4096;
      21: a = 37'd2048;
      22: a = 37'd1024;
      23: a = 37'd512;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

>>> src/point_bearing_angle.sv
// point_bearing_angle: direction of (first - second) as an unsigned angle.
// Input channel: valid_i / stall_o with four signed coordinates; a request
//   is taken at a clock edge with valid_i high and stall_o low.
// Output channel: valid_o / stall_i with bearing_o, radians in [0, 2*pi)
//   with ANGLE_FRAC_BITS fraction bits; a zero vector reads as 0.
// Stages: two front stages (difference, pre-rotation), one stage per CORDIC
//   micro-rotation, three back stages (wrap, round, full-turn wrap).
// Throughput: one request per cycle unless stalled; every stage is a single add/compare.
// Stall: each stage moves when it is empty or the stage after it moves, so
//   bubbles close up while stall_i is high and stall_o rises only when every
//   stage holds a request. Nothing is dropped or repeated.
// Reset: rst_ni clears all stage valid bits; the pipeline comes up empty.
// Depends on pba_pkg, pba_prep, pba_cordic_stage, pba_round.
module point_bearing_angle #(
  parameter int COORD_BITS      = 16,
  parameter int CORDIC_STEPS    = 16,
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic signed [COORD_BITS-1:0]  first_x_i,
  input  logic signed [COORD_BITS-1:0]  first_y_i,
  input  logic signed [COORD_BITS-1:0]  second_x_i,
  input  logic signed [COORD_BITS-1:0]  second_y_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic [pba_pkg::BearingW-1:0]  bearing_o
);

  localparam int W     = COORD_BITS + 28;
  localparam int N     = CORDIC_STEPS;
  localparam int Depth = N + 5;

  logic [Depth-1:0] vld, en;

  pba_pkg::ctl_t                 ctl_s [0:N];
  logic signed [W-1:0]           x_s   [0:N];
  logic signed [W-1:0]           y_s   [0:N];
  logic signed [pba_pkg::ZW-1:0] z_s   [0:N];

  always_comb begin
    en[Depth-1] = !vld[Depth-1] || !stall_i;
    for (int k = Depth - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign stall_o = !en[0];

  pba_prep #(
    .CW (COORD_BITS),
    .W  (W)
  ) u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en[1:0]),
    .valid_i    (valid_i),
    .first_x_i  (first_x_i),
    .first_y_i  (first_y_i),
    .second_x_i (second_x_i),
    .second_y_i (second_y_i),
    .vld_o      (vld[1:0]),
    .ctl_o      (ctl_s[0]),
    .x_o        (x_s[0]),
    .y_o        (y_s[0]),
    .z_o        (z_s[0])
  );

  for (genvar g = 0; g < N; g++) begin : g_step
    pba_cordic_stage #(
      .W    (W),
      .Step (g)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en[g+2]),
      .ctl_i  (ctl_s[g]),
      .x_i    (x_s[g]),
      .y_i    (y_s[g]),
      .z_i    (z_s[g]),
      .ctl_o  (ctl_s[g+1]),
      .x_o    (x_s[g+1]),
      .y_o    (y_s[g+1]),
      .z_o    (z_s[g+1])
    );
    assign vld[g+2] = ctl_s[g+1].valid;
  end

  pba_round #(
    .AF (ANGLE_FRAC_BITS)
  ) u_round (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en[N+4:N+2]),
    .ctl_i     (ctl_s[N]),
    .z_i       (z_s[N]),
    .vld_o     (vld[N+4:N+2]),
    .bearing_o (bearing_o)
  );

  assign valid_o = vld[Depth-1];

`ifndef SYNTH
  // input side is held off only by a full pipe behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (valid_o && stall_i)) else $error("stall_o without backpressure");
  // an accepted request lands in the first stage
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && !stall_o) |=> vld[0]) else $error("accepted request lost at entry");
`endif

endmodule

>>> src/pba_prep.sv
// pba_prep: two front stages, coordinate difference then half-plane
// pre-rotation and scaling into the CORDIC working format. Uses pba_pkg.
module pba_prep #(
  parameter int CW = 16,
  parameter int W  = 44
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [1:0]                 en_i,
  input  logic                       valid_i,
  input  logic signed [CW-1:0]       first_x_i,
  input  logic signed [CW-1:0]       first_y_i,
  input  logic signed [CW-1:0]       second_x_i,
  input  logic signed [CW-1:0]       second_y_i,
  output logic [1:0]                 vld_o,
  output pba_pkg::ctl_t              ctl_o,
  output logic signed [W-1:0]        x_o,
  output logic signed [W-1:0]        y_o,
  output logic signed [pba_pkg::ZW-1:0] z_o
);

  logic signed [CW:0]   dx_d, dy_d, dx_q, dy_q;
  logic                 zero1_d, zero1_q, v1_q;
  logic signed [CW+1:0] ax, ay;
  logic                 neg;
  logic signed [W-1:0]  x_d, y_d, x_q, y_q;
  logic signed [pba_pkg::ZW-1:0] z_d, z_q;
  logic                 zero2_q, v2_q;

  always_comb begin
    dx_d    = {first_x_i[CW-1], first_x_i} - {second_x_i[CW-1], second_x_i};
    dy_d    = {first_y_i[CW-1], first_y_i} - {second_y_i[CW-1], second_y_i};
    zero1_d = (dx_d == '0) && (dy_d == '0);
  end

  always_comb begin
    neg = dx_q[CW];
    ax  = neg ? -((CW+2)'(dx_q)) : (CW+2)'(dx_q);
    ay  = neg ? -((CW+2)'(dy_q)) : (CW+2)'(dy_q);
    x_d = W'(ax) <<< pba_pkg::ScaleBits;
    y_d = W'(ay) <<< pba_pkg::ScaleBits;
    z_d = neg ? pba_pkg::PiQ32 : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en_i[0]) v1_q <= valid_i;
      if (en_i[1]) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0] && valid_i) begin
      dx_q    <= dx_d;
      dy_q    <= dy_d;
      zero1_q <= zero1_d;
    end
    if (en_i[1] && v1_q) begin
      x_q     <= x_d;
      y_q     <= y_d;
      z_q     <= z_d;
      zero2_q <= zero1_q;
    end
  end

  assign vld_o = {v2_q, v1_q};
  assign ctl_o = '{valid: v2_q, zero: zero2_q};
  assign x_o   = x_q;
  assign y_o   = y_q;
  assign z_o   = z_q;

endmodule

>>> src/pba_cordic_stage.sv
// pba_cordic_stage: one registered vectoring micro-rotation of the CORDIC
// chain. Uses pba_pkg for the angle format and arctangent table.
module pba_cordic_stage #(
  parameter int          W    = 44,
  parameter int unsigned Step = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  pba_pkg::ctl_t                 ctl_i,
  input  logic signed [W-1:0]           x_i,
  input  logic signed [W-1:0]           y_i,
  input  logic signed [pba_pkg::ZW-1:0] z_i,
  output pba_pkg::ctl_t                 ctl_o,
  output logic signed [W-1:0]           x_o,
  output logic signed [W-1:0]           y_o,
  output logic signed [pba_pkg::ZW-1:0] z_o
);

  localparam logic [pba_pkg::ZW-1:0] Atan = pba_pkg::atan_q32(Step);

  logic signed [W-1:0]           xs, ys, x_d, y_d, x_q, y_q;
  logic signed [pba_pkg::ZW-1:0] z_d, z_q;
  logic                          pos, v_q, zero_q;

  always_comb begin
    xs  = x_i >>> Step;
    ys  = y_i >>> Step;
    pos = !y_i[W-1];
    if (pos) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + $signed(Atan);
    end else begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - $signed(Atan);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && ctl_i.valid) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      zero_q <= ctl_i.zero;
    end
  end

  assign ctl_o = '{valid: v_q, zero: zero_q};
  assign x_o   = x_q;
  assign y_o   = y_q;
  assign z_o   = z_q;

`ifndef SYNTH
  // x starts in the right half plane and only grows
  a_x_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q |-> !x_q[W-1]) else $error("cordic x went negative");
`endif

endmodule

>>> src/pba_round.sv
// pba_round: three back stages, wrap of negative angles, rounding to the
// output fraction width, and full-turn wrap. Uses pba_pkg.
module pba_round #(
  parameter int AF = 13
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [2:0]                    en_i,
  input  pba_pkg::ctl_t                 ctl_i,
  input  logic signed [pba_pkg::ZW-1:0] z_i,
  output logic [2:0]                    vld_o,
  output logic [pba_pkg::BearingW-1:0]  bearing_o
);

  localparam int Sh = pba_pkg::AtanFrac - AF;
  localparam int Rw = pba_pkg::ZW - Sh;
  localparam int Ow = (Rw > pba_pkg::BearingW) ? Rw : pba_pkg::BearingW;
  localparam logic [pba_pkg::ZW-1:0] Half  = pba_pkg::ZW'(1) << (Sh - 1);
  localparam logic [pba_pkg::ZW-1:0] FullW = (pba_pkg::TwoPiQ32 + Half) >> Sh;
  localparam logic [Rw-1:0]          Full  = FullW[Rw-1:0];

  logic [pba_pkg::ZW-1:0]       zp_d, zp_q, sum;
  logic [Rw-1:0]                r_d, r_q, rf;
  logic [Ow-1:0]                wide;
  logic [pba_pkg::BearingW-1:0] b_d, b_q;
  logic                         v1_q, v2_q, v3_q, zero1_q, zero2_q;

  always_comb begin
    zp_d = z_i[pba_pkg::ZW-1] ? (pba_pkg::ZW'(z_i) + pba_pkg::TwoPiQ32)
                              : pba_pkg::ZW'(z_i);
    sum  = zp_q + Half;
    r_d  = Rw'(sum >> Sh);
    rf   = (r_q >= Full) ? (r_q - Full) : r_q;
    wide = Ow'(rf);
    b_d  = zero2_q ? '0 : wide[pba_pkg::BearingW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en_i[0]) v1_q <= ctl_i.valid;
      if (en_i[1]) v2_q <= v1_q;
      if (en_i[2]) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0] && ctl_i.valid) begin
      zp_q    <= zp_d;
      zero1_q <= ctl_i.zero;
    end
    if (en_i[1] && v1_q) begin
      r_q     <= r_d;
      zero2_q <= zero1_q;
    end
    if (en_i[2] && v2_q) begin
      b_q <= b_d;
    end
  end

  assign vld_o     = {v3_q, v2_q, v1_q};
  assign bearing_o = b_q;

`ifndef SYNTH
  // wrapped angle lies in [0, 2*pi)
  a_wrap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> (zp_q < pba_pkg::TwoPiQ32)) else $error("angle wrap out of range");
`endif

endmodule

>>> dv/testbench.sv
// Testbench for point_bearing_angle: drives coordinate pairs over valid/stall,
// predicts each bearing with a CORDIC atan2 model and checks results in order.
// Depends on pba_pkg and the point_bearing_angle RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int CoordW   = 16;
  localparam int BearingW = pba_pkg::BearingW;

  typedef struct packed {
    logic signed [CoordW-1:0] first_x;
    logic signed [CoordW-1:0] first_y;
    logic signed [CoordW-1:0] second_x;
    logic signed [CoordW-1:0] second_y;
  } point_pair_t;

  class bearing_scoreboard;
    localparam longint PiFix     = 64'sd13493037705;
    localparam longint TwoPiFix  = 64'sd26986075409;
    localparam int     Steps     = 16;
    localparam longint WorkScale = 64'sd16777216;
    localparam int     DropBits  = 32 - 13;

    typedef struct {
      point_pair_t         req;
      logic [BearingW-1:0] bearing;
    } pending_t;

    pending_t    pending_q[$];
    int unsigned n_requests;
    int unsigned n_results;
    int unsigned n_errors;

    // atan(2^-i), 32 fraction bits
    function longint atan_fix(int i);
      case (i)
        0:  return 64'sd3373259426;
        1:  return 64'sd1991351318;
        2:  return 64'sd1052175346;
        3:  return 64'sd534100635;
        4:  return 64'sd268086748;
        5:  return 64'sd134174063;
        6:  return 64'sd67103403;
        7:  return 64'sd33553749;
        8:  return 64'sd16777131;
        9:  return 64'sd8388597;
        10: return 64'sd4194303;
        11: return 64'sd2097152;
        12: return 64'sd1048576;
        13: return 64'sd524288;
        14: return 64'sd262144;
        15: return 64'sd131072;
        default: return 64'sd0;
      endcase
    endfunction

    function logic [BearingW-1:0] predict_bearing(point_pair_t p);
      longint dx, dy, x, y, z, xs, ys, r, turn;
      dx = longint'(p.first_x) - longint'(p.second_x);
      dy = longint'(p.first_y) - longint'(p.second_y);
      if (dx == 0 && dy == 0) return '0;
      if (dx < 0) begin
        x = -dx;
        y = -dy;
        z = PiFix;
      end else begin
        x = dx;
        y = dy;
        z = 0;
      end
      x = x * WorkScale;
      y = y * WorkScale;
      for (int i = 0; i < Steps; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + atan_fix(i);
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - atan_fix(i);
        end
      end
      if (z < 0) z = z + TwoPiFix;
      if (z < 0) z = 0;
      r    = (z + (64'sd1 <<< (DropBits - 1))) >>> DropBits;
      turn = (TwoPiFix + (64'sd1 <<< (DropBits - 1))) >>> DropBits;
      if (r >= turn) r = r - turn;
      return r[BearingW-1:0];
    endfunction

    function void note_request(point_pair_t p);
      pending_t e;
      e.req     = p;
      e.bearing = predict_bearing(p);
      pending_q.push_back(e);
      n_requests++;
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH %s", $time, msg);
      n_errors++;
    endtask

    task check_result(logic [BearingW-1:0] got);
      pending_t e;
      n_results++;
      if (pending_q.size() == 0) begin
        report($sformatf("bearing %0d with no request pending", got));
        return;
      end
      e = pending_q.pop_front();
      if (got !== e.bearing)
        report($sformatf("(%0d,%0d)-(%0d,%0d): bearing %0d, expected %0d",
                         e.req.first_x, e.req.first_y, e.req.second_x, e.req.second_y,
                         got, e.bearing));
    endtask
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     valid_i;
  logic                     stall_o;
  logic signed [CoordW-1:0] first_x_i;
  logic signed [CoordW-1:0] first_y_i;
  logic signed [CoordW-1:0] second_x_i;
  logic signed [CoordW-1:0] second_y_i;
  logic                     valid_o;
  logic                     stall_i;
  logic [BearingW-1:0]      bearing_o;

  bearing_scoreboard sb = new();

  bit          tx_idle = 1'b1;
  bit          rx_idle = 1'b1;
  bit          burst;
  bit          hold_req;
  int unsigned blocked_cycles;

  point_bearing_angle dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (valid_i),
    .stall_o    (stall_o),
    .first_x_i  (first_x_i),
    .first_y_i  (first_y_i),
    .second_x_i (second_x_i),
    .second_y_i (second_y_i),
    .valid_o    (valid_o),
    .stall_i    (stall_i),
    .bearing_o  (bearing_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (valid_o && !stall_i) sb.check_result(bearing_o);
    if (valid_i && stall_o) blocked_cycles++;
  end

  task automatic send_pair(point_pair_t p);
    int unsigned gap;
    if ($urandom_range(0, 40) == 0) tx_idle = !tx_idle;
    gap = (tx_idle && !burst) ? $urandom_range(0, 12) : 0;
    if (gap != 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i    <= 1'b1;
    first_x_i  <= p.first_x;
    first_y_i  <= p.first_y;
    second_x_i <= p.second_x;
    second_y_i <= p.second_y;
    do @(posedge clk_i); while (stall_o);
    sb.note_request(p);
  endtask

  task automatic send_coords(int fx, int fy, int sx, int sy);
    point_pair_t p;
    p.first_x  = CoordW'(fx);
    p.first_y  = CoordW'(fy);
    p.second_x = CoordW'(sx);
    p.second_y = CoordW'(sy);
    send_pair(p);
  endtask

  function automatic logic [CoordW-1:0] corner_coord();
    case ($urandom_range(0, 4))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'hffff;
      default: return 16'h0001;
    endcase
  endfunction

  function automatic point_pair_t random_pair();
    point_pair_t p;
    int unsigned kind;
    kind       = $urandom_range(0, 99);
    p.first_x  = CoordW'($urandom);
    p.first_y  = CoordW'($urandom);
    p.second_x = CoordW'($urandom);
    p.second_y = CoordW'($urandom);
    if (kind >= 55 && kind < 75) begin
      // short vectors
      p.second_x = p.first_x - CoordW'($urandom_range(0, 8)) + 16'sd4;
      p.second_y = p.first_y - CoordW'($urandom_range(0, 8)) + 16'sd4;
    end else if (kind >= 75 && kind < 85) begin
      if ($urandom_range(0, 1) != 0) p.second_x = p.first_x;
      else p.second_y = p.first_y;
    end else if (kind >= 85 && kind < 90) begin
      p.second_x = p.first_x;
      p.second_y = p.first_y;
    end else if (kind >= 90) begin
      p.first_x  = corner_coord();
      p.first_y  = corner_coord();
      p.second_x = corner_coord();
      p.second_y = corner_coord();
    end
    return p;
  endfunction

  initial begin
    int unsigned n;
    stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        n = 100;
      end else begin
        if ($urandom_range(0, 40) == 0) rx_idle = !rx_idle;
        n = rx_idle ? $urandom_range(0, 12) : 0;
      end
      if (n != 0) begin
        stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      stall_i <= 1'b0;
      do @(posedge clk_i); while (!valid_o);
    end
  end

  initial begin
    rst_ni     <= 1'b0;
    valid_i    <= 1'b0;
    first_x_i  <= '0;
    first_y_i  <= '0;
    second_x_i <= '0;
    second_y_i <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero vectors, axes, quadrant extremes, wrap to full turn
    send_coords(0, 0, 0, 0);
    send_coords(-32768, -32768, -32768, -32768);
    send_coords(32767, 32767, 32767, 32767);
    send_coords(32767, 32767, -32768, -32768);
    send_coords(-32768, -32768, 32767, 32767);
    send_coords(32767, 0, -32768, 0);
    send_coords(-32768, 0, 32767, 0);
    send_coords(0, 32767, 0, -32768);
    send_coords(0, -32768, 0, 32767);
    send_coords(32767, -32768, -32768, 32767);
    send_coords(-32768, 32767, 32767, -32768);
    send_coords(32767, -1, -32768, 0);
    send_coords(1, -1, 0, 0);
    send_coords(-1, -1, 0, 0);
    send_coords(-1, 1, 0, 0);
    send_coords(1, 0, 0, 0);
    send_coords(-1, 0, 0, 0);
    send_coords(0, 1, 0, 0);
    send_coords(0, -1, 0, 0);
    send_coords(100, -1, 0, 0);
    send_coords(-5, -1, 0, 0);
    send_coords(-32768, -1, 32767, 0);
    send_coords(12345, -23456, -20000, 30000);

    for (int k = 0; k < 1790; k++) begin
      if (k == 500 || k == 1300) begin
        // long output hold while requests keep coming at full rate
        hold_req = 1'b1;
        burst    = 1'b1;
        repeat (80) send_pair(random_pair());
        burst = 1'b0;
      end
      send_pair(random_pair());
    end
    valid_i <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);

    $display("Covered %0d requests: zero vectors, axes, quadrant corners, full-turn rounding,",
             sb.n_requests);
    $display("short and random vectors; %0d results checked, input stalled on %0d cycles",
             sb.n_results, blocked_cycles);
    if (sb.n_errors == 0 && sb.pending_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", sb.n_errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("timeout with %0d results outstanding", sb.pending_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
